/* rtl/lhs_pkg.sv */
// ----------------------------------------------------------------------------
// lhs_pkg: shared types and codes for the lift homing sequencer
// Phase codes, command codes, beat layouts and the controller state record.
// ----------------------------------------------------------------------------
package lhs_pkg;

	// Controller phases
	localparam logic [2:0] PH_INIT     = 3'd0;
	localparam logic [2:0] PH_FINDZERO = 3'd1;
	localparam logic [2:0] PH_ZERO     = 3'd2;
	localparam logic [2:0] PH_RISING   = 3'd3;
	localparam logic [2:0] PH_END      = 3'd4;
	localparam logic [2:0] PH_RETURN   = 3'd5;
	localparam logic [2:0] PH_STOP     = 3'd6;
	localparam logic [2:0] PH_FAULT    = 3'd7;

	// Status reported for both stop and fault
	localparam logic [2:0] STATUS_HALT = 3'd6;

	// Brake pin actions
	localparam logic [1:0] BRK_NONE = 2'd0;
	localparam logic [1:0] BRK_LOW  = 2'd1;
	localparam logic [1:0] BRK_HIGH = 2'd2;

	// Motor state commands
	localparam logic [1:0] DRV_NONE    = 2'd0;
	localparam logic [1:0] DRV_DISABLE = 2'd1;
	localparam logic [1:0] DRV_ENABLE  = 2'd2;
	localparam logic [1:0] DRV_START   = 2'd3;

	// Mode requests
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_SPEED = 2'd1;
	localparam logic [1:0] MODE_POSI  = 2'd2;

	// Sampled motor state
	localparam logic [1:0] DST_IDLE  = 2'd0;
	localparam logic [1:0] DST_READY = 2'd1;
	localparam logic [1:0] DST_FAULT = 2'd3;

	// Sampled motor mode
	localparam logic [1:0] DMODE_SPEED = 2'd0;
	localparam logic [1:0] DMODE_POSI  = 2'd1;

	// Proximity switch levels
	localparam logic [1:0] PROX_LOW  = 2'd0;
	localparam logic [1:0] PROX_HIGH = 2'd1;

	// Host commands
	localparam logic [1:0] HOST_NONE  = 2'd0;
	localparam logic [1:0] HOST_RAISE = 2'd1;
	localparam logic [1:0] HOST_LOWER = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_RISE_DISTANCE    = 2'd0;
	localparam logic [1:0] REG_HOME_SPEED       = 2'd1;
	localparam logic [1:0] REG_RETURN_OVERSHOOT = 2'd2;
	localparam logic [1:0] REG_DWELL_LIMIT      = 2'd3;

	localparam int IN_BITS   = 42;
	localparam int OUT_BITS  = 43;
	localparam int IN_BYTES  = (IN_BITS + 7) / 8;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
	localparam int CFG_W     = 30;

	typedef struct packed {
		logic [1:0]  host_value;
		logic        host_write;
		logic [31:0] position;
		logic [1:0]  drive_mode;
		logic [1:0]  drive_status;
		logic [1:0]  prox_level;
		logic        stop_pressed;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status_code;
		logic [31:0] target_value;
		logic        target_valid;
		logic [1:0]  mode_command;
		logic        disable_first;
		logic [1:0]  drive_command;
		logic [1:0]  brake_action;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [1:0]  pending_command;
		logic [15:0] dwell_count;
	} ctl_state_t;

	typedef struct packed {
		logic [29:0] rise_distance;
		logic [19:0] home_speed;
		logic [29:0] return_overshoot;
		logic [15:0] dwell_limit;
	} cfg_t;

endpackage

/* rtl/lhs_step.sv */
// ----------------------------------------------------------------------------
// lhs_step: one tick of the homing controller
// Combinational next-state and output decision for a single sampled tick.
// ----------------------------------------------------------------------------
module lhs_step (
	input  lhs_pkg::ctl_state_t st,
	input  lhs_pkg::cfg_t       cfg,
	input  lhs_pkg::in_item_t   item,
	output lhs_pkg::ctl_state_t st_next,
	output lhs_pkg::out_item_t  res
);
	import lhs_pkg::*;

	logic [2:0]  ph;
	logic [1:0]  pend;
	logic [15:0] dwell;
	logic [31:0] apos;
	logic        reached;
	logic [30:0] lower_sum;

	// Magnitude of the position; the most negative value maps to 2^31.
	assign apos = item.position[31] ? (~item.position + 32'd1) : item.position;
	// With a zero distance the threshold would wrap to all ones, so zero counts as reached outright.
	assign reached = (cfg.rise_distance == '0) ||
		(apos >= ({2'b00, cfg.rise_distance} - 32'd1));
	assign lower_sum = {1'b0, cfg.rise_distance} + {1'b0, cfg.return_overshoot};

	always_comb begin
		ph    = st.phase;
		pend  = st.pending_command;
		dwell = st.dwell_count;
		res   = '0;

		if (item.host_write) begin
			pend = item.host_value;
		end

		if (item.stop_pressed && ph != PH_STOP) begin
			res.drive_command = DRV_DISABLE;
			res.brake_action  = BRK_LOW;
			ph = PH_STOP;
		end

		if (ph inside {PH_INIT, PH_FINDZERO, PH_RISING, PH_RETURN, PH_STOP}) begin
			pend = HOST_NONE;
		end

		if (item.drive_status == DST_FAULT) begin
			ph = PH_FAULT;
		end

		case (ph)
			PH_INIT: begin
				if (item.prox_level == PROX_LOW) begin
					if (item.drive_mode != DMODE_SPEED) begin
						res.mode_command = MODE_SPEED;
					end else if (item.drive_status != DST_READY) begin
						res.drive_command = DRV_ENABLE;
					end else begin
						res.drive_command = DRV_START;
						res.target_valid  = 1'b1;
						res.target_value  = {12'd0, cfg.home_speed};
						ph = PH_FINDZERO;
					end
				end else if (item.prox_level == PROX_HIGH) begin
					if (item.drive_mode != DMODE_POSI) begin
						res.mode_command = MODE_POSI;
					end
					ph = PH_ZERO;
				end
			end
			PH_FINDZERO: begin
				if (item.prox_level == PROX_HIGH) begin
					res.target_valid = 1'b1;
					res.target_value = '0;
					res.mode_command = MODE_POSI;
					ph = PH_ZERO;
				end
			end
			PH_ZERO: begin
				if (item.drive_mode == DMODE_POSI) begin
					res.brake_action  = BRK_LOW;
					res.drive_command = DRV_DISABLE;
					if (pend == HOST_RAISE) begin
						// The disable above always precedes this enable or start.
						res.brake_action  = BRK_HIGH;
						res.disable_first = 1'b1;
						if (item.drive_status != DST_READY) begin
							res.target_valid  = 1'b1;
							res.target_value  = -{2'b00, cfg.rise_distance};
							res.drive_command = DRV_ENABLE;
						end else begin
							res.drive_command = DRV_START;
							pend = HOST_NONE;
							ph = PH_RISING;
						end
					end
				end
			end
			PH_RISING: begin
				dwell = dwell + 16'd1;
				if (reached && dwell > cfg.dwell_limit) begin
					dwell = '0;
					res.brake_action  = BRK_LOW;
					res.drive_command = DRV_DISABLE;
					ph = PH_END;
				end
			end
			PH_END: begin
				if (pend == HOST_LOWER) begin
					res.brake_action = BRK_HIGH;
					if (item.drive_status != DST_READY) begin
						res.target_valid  = 1'b1;
						res.target_value  = {1'b0, lower_sum};
						res.drive_command = DRV_ENABLE;
					end else begin
						res.drive_command = DRV_START;
						pend = HOST_NONE;
						ph = PH_RETURN;
					end
				end
			end
			PH_RETURN: begin
				if (item.prox_level == PROX_HIGH) begin
					ph = PH_ZERO;
				end
			end
			PH_STOP: begin
				if (!item.stop_pressed) begin
					res.brake_action = BRK_HIGH;
					ph = PH_INIT;
				end
			end
			default: begin
				res.brake_action = BRK_LOW;
				if (item.drive_status == DST_IDLE) begin
					res.brake_action = BRK_HIGH;
					ph = PH_INIT;
				end
			end
		endcase

		res.status_code = (ph == PH_FAULT) ? STATUS_HALT : ph;
		st_next.phase           = ph;
		st_next.pending_command = pend;
		st_next.dwell_count     = dwell;
	end

endmodule

/* rtl/lift_homing_sequencer.sv */
// ----------------------------------------------------------------------------
// lift_homing_sequencer: lift homing and raise/lower sequencer
// Steps the homing, raise and lower phases once per sampled tick beat.
// ----------------------------------------------------------------------------
// Each input beat is one control tick and yields exactly one result beat. A
// tick is taken into an input register, evaluated by the step logic against
// the phase, latched command and dwell counter, and written to the output
// register: one beat per cycle sustained while the output is not stalled.
// The output register lets a new tick enter while a result waits. Configure
// the four registers only while no tick is in flight.
module lift_homing_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	// stop_pressed, prox_level[1:0], drive_status[1:0], drive_mode[1:0],
	// position[31:0], host_write, host_value[1:0], zero fill
	input  logic [lhs_pkg::IN_BYTES*8-1:0]     s_tdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// brake_action[1:0], drive_command[1:0], disable_first, mode_command[1:0],
	// target_valid, target_value[31:0], status_code[2:0], zero fill
	output logic [lhs_pkg::OUT_BYTES*8-1:0]    m_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [lhs_pkg::CFG_W-1:0]          cfg_data
);
	import lhs_pkg::*;

	cfg_t       cfg_q;
	ctl_state_t state_q;
	ctl_state_t state_next;
	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  res;
	out_item_t  res_s2;
	logic       valid_s2;
	logic       out_ready;
	logic       adv;

	assign out_ready = !valid_s2 || m_tready;
	assign adv       = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_distance    <= 30'd3000000;
			cfg_q.home_speed       <= 20'd2500;
			cfg_q.return_overshoot <= 30'd50000;
			cfg_q.dwell_limit      <= 16'd4500;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RISE_DISTANCE:    cfg_q.rise_distance    <= cfg_data;
				REG_HOME_SPEED:       cfg_q.home_speed       <= cfg_data[19:0];
				REG_RETURN_OVERSHOOT: cfg_q.return_overshoot <= cfg_data;
				REG_DWELL_LIMIT:      cfg_q.dwell_limit      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{phase: PH_INIT, pending_command: HOST_NONE, dwell_count: '0};
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_ready) begin
				valid_s2 <= valid_s1;
			end
			if (adv) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= s_tdata[IN_BITS-1:0];
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	lhs_step u_step (
		.st      (state_q),
		.cfg     (cfg_q),
		.item    (item_s1),
		.st_next (state_next),
		.res     (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, res_s2};

endmodule

/* rtl/lhs_checker.sv */
// ----------------------------------------------------------------------------
// lhs_checker: port-level checks for the lift homing sequencer
// Watches result beats for consistent command fields and a held stall, and input readiness.
// ----------------------------------------------------------------------------
module lhs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic [lhs_pkg::OUT_BYTES*8-1:0] m_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready
);
	import lhs_pkg::*;

	// A disable ahead of a start or enable must leave that start or enable last.
	a_disfirst: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[4]) |-> (m_tdata[3:2] == DRV_ENABLE ||
			m_tdata[3:2] == DRV_START))
		else $error("disable_first without a later enable or start");

	// No target issued means the target field reads zero.
	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[7]) |-> (m_tdata[39:8] == '0))
		else $error("target value nonzero without target_valid");

	// Fault is folded into the halt status; code 7 never appears.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[42:40] != PH_FAULT && m_tdata[1:0] != 2'd3))
		else $error("illegal status or brake code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result beat changed while stalled");

	// With no result waiting the input side is always open.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result waiting");

endmodule

bind lift_homing_sequencer lhs_checker u_lhs_checker (.*);
